// File: rtl/uhjs_pkg.sv
// Shared types, constants and helpers of the UTF-8 Hangul jamo splitter.
package uhjs_pkg;

  // Result kinds as they appear on the output port.
  typedef enum logic [2:0] {
    KindPlain    = 3'd0,
    KindLead     = 3'd1,
    KindVowel    = 3'd2,
    KindTrail    = 3'd3,
    KindLineEnd  = 3'd4,
    KindLineFull = 3'd5
  } uhjs_kind_e;

  localparam logic [7:0]  ByteLf       = 8'h0A;
  localparam logic [7:0]  ByteCr       = 8'h0D;
  localparam logic [7:0]  ByteAsciiTop = 8'h80;
  localparam logic [1:0]  LastPackIdx  = 2'd2;     // third byte closes a char

  localparam logic [23:0] SylPackedLo  = 24'hEAB080;
  localparam logic [23:0] SylPackedHi  = 24'hED9EA3;
  localparam logic [15:0] SylBase      = 16'hAC00;
  localparam logic [15:0] SylLast      = 16'hD7A3;
  localparam logic [15:0] LeadBase     = 16'h1100;
  localparam logic [15:0] VowelBase    = 16'h1161;
  localparam logic [15:0] TrailBase    = 16'h11A7;
  localparam int unsigned VowelCount   = 21;
  localparam int unsigned TrailCount   = 28;

  // floor(s/28) = (s*9363)>>18 exact for s < 11172
  localparam logic [13:0] TrailRecip   = 14'd9363;
  localparam int unsigned TrailShift   = 18;
  // floor(q/21) = (q*391)>>13 exact for q < 399
  localparam logic [8:0]  VowelRecip   = 9'd391;
  localparam int unsigned VowelShift   = 13;

  // One queued unit of work: a line end or one finished character.
  typedef struct packed {
    logic        line_end;
    logic        hangul;
    logic        full;      // line closes after this character
    logic [23:0] word;      // packed UTF-8 bytes
    logic [8:0]  quot;      // syllable offset / 28
  } uhjs_op_t;

  // Code point to UTF-8 code points in 0x0800..0xFFFF, packed big-end first.
  function automatic logic [23:0] pack3(input logic [15:0] cp);
    return {4'hE, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
  endfunction

  // Code point of a packed three-byte word.
  function automatic logic [15:0] unpack3(input logic [23:0] word);
    return {word[19:16], word[13:8], word[5:0]};
  endfunction

endpackage

// File: rtl/utf8_hangul_jamo_splitter_core.sv
// Top level of the UTF-8 Hangul jamo splitter.
//
// Input channel (in_valid_i/in_ready_o): one UTF-8 byte or an end-of-input
// marker per beat. Output channel (out_valid_o/out_ready_i): one result beat
// carrying code_word_o, kind_o and last_o; last_o marks the final beat
// caused by an input byte. Bytes that give no result (partial characters,
// the byte after CR) produce no output beat at all.
// Config: cfg_we_i writes cfg_wdata_i into max_chars; write
// only while nothing is in flight.
// Path: a byte's first result beat goes front -> queue -> work register ->
// output reg. Throughput: one input byte per cycle unless the queue is full
// and one result beat per cycle unless out_ready_i stalls the output; a
// Hangul syllable takes three input beats and gives three or four results,
// so the output beat rate is the limit, set by the back-end sequencer.
// Stall: when out_ready_i is low the output register holds, the back end
// stops and the op queue (QueueDepth entries) fills; in_ready_o drops only
// when the queue is full. No clearing pass at reset: all control state and
// max_chars (143) are reset asynchronously by rst_ni.
module utf8_hangul_jamo_splitter_core
  import uhjs_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] code_word_o,
  output logic [2:0]  kind_o,
  output logic        last_o
);

  uhjs_op_t push_op, head_op;
  logic     push, q_full, q_valid, q_pop;

  // classify bytes, track char packing and line length
  uhjs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .op_o           (push_op)
  );

  // decouples byte intake from result expansion
  uhjs_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (head_op)
  );

  // split syllables and sequence 1..4 result beats per op
  uhjs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .op_i        (head_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_word_o (code_word_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

endmodule

// File: rtl/uhjs_front.sv
// Front end: byte accept, character packing, line tracking, op classification.
module uhjs_front
  import uhjs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_input_i,
  input  logic       q_full_i,
  output logic       push_o,
  output uhjs_op_t   op_o
);

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        swal_q, swal_d;
  logic [7:0]  line_q, line_d;
  logic [7:0]  max_q;

  logic        accept;
  logic [23:0] packed_w;
  logic [8:0]  line_inc;
  logic        line_full;
  logic        char_done;
  logic [15:0] cp;
  logic [15:0] syl_ofs;
  logic        is_syl;
  logic [27:0] quot_prod;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign packed_w  = {pend_q, text_byte_i};
  assign line_inc  = {1'b0, line_q} + 9'd1;
  assign line_full = line_inc >= {1'b0, max_q};   // limit 0 behaves as 1
  assign char_done = (text_byte_i < ByteAsciiTop) || (cnt_q == LastPackIdx);
  assign cp        = unpack3(packed_w);
  assign syl_ofs   = cp - SylBase;
  assign is_syl    = (packed_w >= SylPackedLo) && (packed_w <= SylPackedHi) &&
                     (cp >= SylBase) && (cp <= SylLast);
  assign quot_prod = 28'(syl_ofs[13:0]) * 28'(TrailRecip);

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    swal_d = swal_q;
    line_d = line_q;
    push_o = 1'b0;
    op_o   = '0;
    if (accept) begin
      priority if (end_of_input_i) begin
        pend_d = '0;
        cnt_d  = '0;
        swal_d = 1'b0;
        line_d = '0;
        push_o = 1'b1;
        op_o.line_end = 1'b1;
      end else if (swal_q) begin
        swal_d = 1'b0;                          // byte after CR is dropped
      end else if (text_byte_i == ByteLf || text_byte_i == ByteCr) begin
        pend_d = '0;
        cnt_d  = '0;
        line_d = '0;
        swal_d = (text_byte_i == ByteCr);
        push_o = 1'b1;
        op_o.line_end = 1'b1;
      end else if (char_done) begin
        pend_d = '0;
        cnt_d  = '0;
        line_d = line_full ? 8'd0 : line_inc[7:0];
        push_o = 1'b1;
        op_o.hangul = is_syl;
        op_o.full   = line_full;
        op_o.word   = packed_w;
        op_o.quot   = quot_prod[TrailShift +: 9];
      end else begin
        pend_d = packed_w[15:0];
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      swal_q <= 1'b0;
      line_q <= '0;
      max_q  <= 8'd143;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      swal_q <= swal_d;
      line_q <= line_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: rtl/uhjs_fifo.sv
// Small op queue between front and back end.
module uhjs_fifo
  import uhjs_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  uhjs_op_t data_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output uhjs_op_t data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  uhjs_op_t         mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/uhjs_back.sv
// Back end: jamo split of a queued op and beat sequencing into the output register.
module uhjs_back
  import uhjs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  uhjs_op_t    op_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] code_word_o,
  output logic [2:0]  kind_o,
  output logic        last_o
);

  // working op
  logic        wv_q;
  logic [1:0]  phase_q;
  logic        w_end_q, w_hangul_q, w_full_q;
  logic [23:0] w_word_q;
  logic [4:0]  l_q, v_q, t_q;

  // output register
  logic        ov_q;
  logic [23:0] code_q;
  uhjs_kind_e  kind_q;
  logic        last_q;

  // split of the queue head
  logic [15:0] head_ofs;
  logic [17:0] lead_prod;
  logic [4:0]  l_d;
  logic [13:0] t_wide;
  logic [8:0]  v_wide;

  logic        out_free, emit, work_done;
  logic [1:0]  last_phase;
  logic        beat_last;
  logic [23:0] beat_word;
  uhjs_kind_e  beat_kind;

  assign head_ofs  = unpack3(op_i.word) - SylBase;
  assign lead_prod = 18'(op_i.quot) * 18'(VowelRecip);
  assign l_d       = lead_prod[VowelShift +: 5];
  assign t_wide    = head_ofs[13:0] - 14'(op_i.quot) * 14'(TrailCount);
  assign v_wide    = op_i.quot - 9'(l_d) * 9'(VowelCount);

  assign out_free   = !ov_q || out_ready_i;
  assign emit       = wv_q && out_free;
  assign last_phase = w_hangul_q ? (w_full_q ? 2'd3 : 2'd2) : (w_full_q ? 2'd1 : 2'd0);
  assign beat_last  = w_end_q || (phase_q == last_phase);
  assign work_done  = emit && beat_last;
  assign q_pop_o    = q_valid_i && (!wv_q || work_done);

  always_comb begin
    beat_word = '0;
    beat_kind = KindLineFull;
    if (w_end_q) begin
      beat_kind = KindLineEnd;
    end else if (w_hangul_q) begin
      unique case (phase_q)
        2'd0: begin
          beat_kind = KindLead;
          beat_word = pack3(LeadBase + 16'(l_q));
        end
        2'd1: begin
          beat_kind = KindVowel;
          beat_word = pack3(VowelBase + 16'(v_q));
        end
        2'd2: begin
          beat_kind = KindTrail;
          beat_word = (t_q == '0) ? 24'd0 : pack3(TrailBase + 16'(t_q));
        end
        default: beat_kind = KindLineFull;
      endcase
    end else if (phase_q == 2'd0) begin
      beat_kind = KindPlain;
      beat_word = w_word_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      w_end_q    <= op_i.line_end;
      w_hangul_q <= op_i.hangul;
      w_full_q   <= op_i.full;
      w_word_q   <= op_i.word;
      l_q        <= l_d;
      v_q        <= v_wide[4:0];
      t_q        <= t_wide[4:0];
    end
    if (emit) begin
      code_q <= beat_word;
      kind_q <= beat_kind;
      last_q <= beat_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q    <= 1'b0;
      phase_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (q_pop_o) begin
        wv_q    <= 1'b1;
        phase_q <= '0;
      end else if (work_done) begin
        wv_q    <= 1'b0;
      end else if (emit) begin
        phase_q <= phase_q + 2'd1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign code_word_o = code_q;
  assign kind_o      = kind_q;
  assign last_o      = last_q;

endmodule

// File: rtl/uhjs_checker.sv
// Port-level checks of the splitter, bound to the top level.
module uhjs_checker
  import uhjs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] code_word_o,
  input logic [2:0]  kind_o,
  input logic        last_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(code_word_o) && $stable(kind_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // line markers carry no code word
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindLineEnd || kind_o == KindLineFull) |->
      code_word_o == 24'd0)
    else $error("line marker with nonzero code word");

  // lead and vowel are always followed by more jamo
  a_jamo_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindLead || kind_o == KindVowel) |-> !last_o)
    else $error("lead or vowel jamo flagged last");

  // a line end is the only result of its byte
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindLineEnd |-> last_o)
    else $error("line end not flagged last");

endmodule

bind utf8_hangul_jamo_splitter_core uhjs_checker u_uhjs_checker (.*);
